// ===== hdl/scpl_pkg.sv =====
// Shared types and constants for the slab-chained posting list block.
// No dependencies; used by every module under hdl/ except scpl_ram.
package scpl_pkg;

    localparam int TERM_SLOTS = 256;
    localparam int POOL_SLABS = 8;
    localparam int SLAB_CAP   = 8;

    localparam int TERM_W  = $clog2(TERM_SLOTS);
    localparam int SLAB_W  = $clog2(POOL_SLABS);
    localparam int IDX_W   = $clog2(SLAB_CAP);
    localparam int FILL_W  = $clog2(SLAB_CAP + 1);
    localparam int POOL_W  = $clog2(POOL_SLABS + 1);
    localparam int ENTRY_W = SLAB_W + IDX_W;

    localparam int TID_W  = 16;
    localparam int DOC_W  = 32;
    localparam int TCNT_W = 9;
    localparam int SSZ_W  = 4;
    localparam int SLIM_W = 4;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 9;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_TERM_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SLAB_DEPTH = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SLAB_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_NO_SLABS = 3'd1,
        ST_BAD_TERM = 3'd2,
        ST_POSTING  = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_POST
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    accept;
        logic    commit;
        logic    start_read;
        logic    advance;
        logic    walk;
        logic    load;
        t_status status;
        logic    last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic act;
        logic in_range;
        logic has_list;
        logic need_slab;
        logic pool_full;
        logic rd_last;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/scpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/scpl_ctrl.sv =====
// Controller FSM: sequences lookup, append commit and chain walk.
// Depends on scpl_pkg.
module scpl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  scpl_pkg::t_stat i_stat,
    output scpl_pkg::t_cmd  o_cmd
);

    scpl_pkg::t_state r_state;
    scpl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scpl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.status = scpl_pkg::ST_APPENDED;
        case (r_state)
            scpl_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = scpl_pkg::S_LOOK;
                end
            end
            scpl_pkg::S_LOOK: begin
                if (i_stat.act == scpl_pkg::ACT_APPEND) begin
                    if (i_stat.out_free) begin
                        o_cmd.load = 1'b1;
                        o_cmd.last = 1'b1;
                        n_state    = scpl_pkg::S_IDLE;
                        if (!i_stat.in_range) begin
                            o_cmd.status = scpl_pkg::ST_BAD_TERM;
                        end else if (i_stat.need_slab && i_stat.pool_full) begin
                            o_cmd.status = scpl_pkg::ST_NO_SLABS;
                        end else begin
                            o_cmd.status = scpl_pkg::ST_APPENDED;
                            o_cmd.commit = 1'b1;
                        end
                    end
                end else if (!i_stat.in_range || !i_stat.has_list) begin
                    if (i_stat.out_free) begin
                        o_cmd.load   = 1'b1;
                        o_cmd.last   = 1'b1;
                        o_cmd.status = scpl_pkg::ST_EMPTY;
                        n_state      = scpl_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.start_read = 1'b1;
                    n_state          = scpl_pkg::S_POST;
                end
            end
            scpl_pkg::S_POST: begin
                o_cmd.walk = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.status = scpl_pkg::ST_POSTING;
                    o_cmd.last   = i_stat.rd_last;
                    if (i_stat.rd_last) begin
                        n_state = scpl_pkg::S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = scpl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/scpl_dp.sv =====
// Datapath: config registers, list heads/tails, slab pool, entry store, result register.
// Depends on scpl_pkg and scpl_ram.
module scpl_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_action,
    input  logic [scpl_pkg::TID_W-1:0]    i_term_id,
    input  logic [scpl_pkg::DOC_W-1:0]    i_doc_id,
    input  logic                          i_cfg_valid,
    input  logic [scpl_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [scpl_pkg::CDAT_W-1:0]   i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [2:0]                    o_status,
    output logic [scpl_pkg::DOC_W-1:0]    o_posting,
    output logic                          o_last,
    input  scpl_pkg::t_cmd                i_cmd,
    output scpl_pkg::t_stat               o_stat
);

    // config
    logic [scpl_pkg::TCNT_W-1:0] r_term_count;
    logic [scpl_pkg::SSZ_W-1:0]  r_slab_depth;
    logic [scpl_pkg::SLIM_W-1:0] r_slab_limit;

    // item
    logic                       r_act;
    logic [scpl_pkg::TID_W-1:0] r_tid;
    logic [scpl_pkg::DOC_W-1:0] r_doc;

    // list and pool state
    logic [scpl_pkg::TERM_SLOTS-1:0] r_has_list;
    logic [scpl_pkg::POOL_SLABS-1:0] r_has_next;
    logic [scpl_pkg::SLAB_W-1:0]     r_next [scpl_pkg::POOL_SLABS];
    logic [scpl_pkg::FILL_W-1:0]     r_fill [scpl_pkg::POOL_SLABS];
    logic [scpl_pkg::POOL_W-1:0]     r_pool_top;

    // walk
    logic [scpl_pkg::SLAB_W-1:0] r_slab;
    logic [scpl_pkg::IDX_W-1:0]  r_idx;

    // result
    logic                       r_out_valid;
    scpl_pkg::t_status          r_status;
    logic [scpl_pkg::DOC_W-1:0] r_posting;
    logic                       r_last;

    logic [scpl_pkg::SLAB_W-1:0]  head_q;
    logic [scpl_pkg::SLAB_W-1:0]  tail_q;
    logic [scpl_pkg::DOC_W-1:0]   entry_q;
    logic [scpl_pkg::TERM_W-1:0]  term_a;
    logic [scpl_pkg::TCNT_W-1:0]  tcnt_sat;
    logic [scpl_pkg::SSZ_W-1:0]   size_sat;
    logic [scpl_pkg::SLIM_W-1:0]  limit_sat;
    logic [scpl_pkg::SLAB_W-1:0]  fill_addr;
    logic [scpl_pkg::FILL_W-1:0]  fill_sel;
    logic [scpl_pkg::FILL_W-1:0]  idx_inc;
    logic                         has_list;
    logic                         need_slab;
    logic                         pool_full;
    logic                         in_range;
    logic                         rd_last;
    logic                         out_free;
    logic [scpl_pkg::SLAB_W-1:0]  new_slab;
    logic [scpl_pkg::SLAB_W-1:0]  ws;
    logic [scpl_pkg::IDX_W-1:0]   wf;
    logic [scpl_pkg::SLAB_W-1:0]  n_slab;
    logic [scpl_pkg::IDX_W-1:0]   n_idx;
    logic [scpl_pkg::ENTRY_W-1:0] ent_raddr;

    assign term_a    = r_tid[scpl_pkg::TERM_W-1:0];
    assign tcnt_sat  = (r_term_count > scpl_pkg::TCNT_W'(scpl_pkg::TERM_SLOTS))
                       ? scpl_pkg::TCNT_W'(scpl_pkg::TERM_SLOTS) : r_term_count;
    assign size_sat  = (r_slab_depth > scpl_pkg::SSZ_W'(scpl_pkg::SLAB_CAP))
                       ? scpl_pkg::SSZ_W'(scpl_pkg::SLAB_CAP) : r_slab_depth;
    assign limit_sat = (r_slab_limit > scpl_pkg::SLIM_W'(scpl_pkg::POOL_SLABS))
                       ? scpl_pkg::SLIM_W'(scpl_pkg::POOL_SLABS) : r_slab_limit;
    assign in_range  = r_tid < scpl_pkg::TID_W'(tcnt_sat);
    assign has_list  = r_has_list[term_a];
    assign fill_addr = i_cmd.walk ? r_slab : tail_q;
    assign fill_sel  = r_fill[fill_addr];
    assign need_slab = !has_list || (fill_sel >= scpl_pkg::FILL_W'(size_sat));
    assign pool_full = scpl_pkg::SLIM_W'(r_pool_top) >= limit_sat;
    assign idx_inc   = scpl_pkg::FILL_W'(r_idx) + scpl_pkg::FILL_W'(1);
    assign rd_last   = (idx_inc >= fill_sel) && !r_has_next[r_slab];
    assign out_free  = !r_out_valid || i_out_ready;
    assign new_slab  = r_pool_top[scpl_pkg::SLAB_W-1:0];
    assign ws        = need_slab ? new_slab : tail_q;
    assign wf        = need_slab ? '0 : fill_sel[scpl_pkg::IDX_W-1:0];

    always_comb begin
        if (idx_inc < fill_sel) begin
            n_slab = r_slab;
            n_idx  = idx_inc[scpl_pkg::IDX_W-1:0];
        end else begin
            n_slab = r_next[r_slab];
            n_idx  = '0;
        end
        ent_raddr = i_cmd.start_read ? {head_q, {scpl_pkg::IDX_W{1'b0}}} : {n_slab, n_idx};
    end

    assign o_stat.act       = r_act;
    assign o_stat.in_range  = in_range;
    assign o_stat.has_list  = has_list;
    assign o_stat.need_slab = need_slab;
    assign o_stat.pool_full = pool_full;
    assign o_stat.rd_last   = rd_last;
    assign o_stat.out_free  = out_free;

    scpl_ram #(.WIDTH(scpl_pkg::SLAB_W), .DEPTH(scpl_pkg::TERM_SLOTS)) u_head (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && need_slab && !has_list),
        .i_waddr (term_a),
        .i_wdata (new_slab),
        .i_re    (i_cmd.accept),
        .i_raddr (i_term_id[scpl_pkg::TERM_W-1:0]),
        .o_rdata (head_q)
    );

    scpl_ram #(.WIDTH(scpl_pkg::SLAB_W), .DEPTH(scpl_pkg::TERM_SLOTS)) u_tail (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && need_slab),
        .i_waddr (term_a),
        .i_wdata (new_slab),
        .i_re    (i_cmd.accept),
        .i_raddr (i_term_id[scpl_pkg::TERM_W-1:0]),
        .o_rdata (tail_q)
    );

    scpl_ram #(.WIDTH(scpl_pkg::DOC_W), .DEPTH(scpl_pkg::POOL_SLABS * scpl_pkg::SLAB_CAP)) u_ent (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr ({ws, wf}),
        .i_wdata (r_doc),
        .i_re    (i_cmd.start_read || i_cmd.advance),
        .i_raddr (ent_raddr),
        .o_rdata (entry_q)
    );

    // control state
    // slabs are never reused, so a fresh slab's link bit is still clear from reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= scpl_pkg::TCNT_W'(scpl_pkg::TERM_SLOTS);
            r_slab_depth <= scpl_pkg::SSZ_W'(scpl_pkg::SLAB_CAP);
            r_slab_limit <= scpl_pkg::SLIM_W'(scpl_pkg::POOL_SLABS);
            r_has_list   <= '0;
            r_has_next   <= '0;
            r_pool_top   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    scpl_pkg::CFG_TERM_COUNT: r_term_count <= i_cfg_data;
                    scpl_pkg::CFG_SLAB_DEPTH: r_slab_depth <= i_cfg_data[scpl_pkg::SSZ_W-1:0];
                    scpl_pkg::CFG_SLAB_LIMIT: r_slab_limit <= i_cfg_data[scpl_pkg::SLIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit && need_slab) begin
                r_pool_top <= r_pool_top + scpl_pkg::POOL_W'(1);
                if (!has_list) begin
                    r_has_list[term_a] <= 1'b1;
                end else begin
                    r_has_next[tail_q] <= 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act <= i_action;
            r_tid <= i_term_id;
            r_doc <= i_doc_id;
        end
        if (i_cmd.commit) begin
            r_fill[ws] <= scpl_pkg::FILL_W'(wf) + scpl_pkg::FILL_W'(1);
            if (need_slab && has_list) begin
                r_next[tail_q] <= new_slab;
            end
        end
        if (i_cmd.start_read) begin
            r_slab <= head_q;
            r_idx  <= '0;
        end else if (i_cmd.advance) begin
            r_slab <= n_slab;
            r_idx  <= n_idx;
        end
        if (i_cmd.load) begin
            r_status  <= i_cmd.status;
            r_posting <= (i_cmd.status == scpl_pkg::ST_POSTING) ? entry_q : '0;
            r_last    <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_posting   = r_posting;
    assign o_last      = r_last;

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_top <= scpl_pkg::POOL_W'(scpl_pkg::POOL_SLABS))
        else $error("pool pointer past pool size");
    a_commit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (in_range && !(need_slab && pool_full)))
        else $error("append committed without room or with bad term");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> out_free)
        else $error("result register overwritten");
    a_adv_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> !rd_last)
        else $error("walk advanced past final posting");

endmodule

// ===== hdl/slab_chained_posting_lists.sv =====
// Top level of the slab-chained posting list block.
// Depends on scpl_pkg, scpl_ctrl, scpl_dp (and scpl_ram through scpl_dp).
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  input   | i_valid / o_ready          | i_action, i_term_id, i_doc_id
//  output  | o_valid / i_ready          | o_status, o_posting, o_last
//  config  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An append or a rejected/empty read passes through accept, then the lookup
// of the term's head/tail RAMs with the update and result load. A read goes
// through accept, lookup and the first entry read to its first posting, then
// loads a further posting whenever the output register is free, read through
// the registered read port of the entry RAM walked along the slab chain.
// Reset (synchronous, i_rst_n low) clears list valid bits, the pool pointer
// and the config registers to their defaults; no clearing pass is needed.
// Output stalls hold the FSM in place; a new input transaction is taken as
// soon as the last result sits in the output register. Config is always ready.
module slab_chained_posting_lists (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_action,
    input  logic [scpl_pkg::TID_W-1:0]     i_term_id,
    input  logic [scpl_pkg::DOC_W-1:0]     i_doc_id,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_status,
    output logic [scpl_pkg::DOC_W-1:0]     o_posting,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scpl_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [scpl_pkg::CDAT_W-1:0]    i_cfg_data
);

    scpl_pkg::t_cmd  cmd;
    scpl_pkg::t_stat stat;

    // config writes land directly in the datapath registers
    assign o_cfg_ready = 1'b1;

    scpl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    scpl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_term_id   (i_term_id),
        .i_doc_id    (i_doc_id),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_status    (o_status),
        .o_posting   (o_posting),
        .o_last      (o_last),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ===== bench/scpl_checker.sv =====
// Checker for slab_chained_posting_lists: watches the config, input and output channels,
// predicts the results of each accepted transaction and compares them in order.
// Depends on scpl_pkg for widths, status codes, actions and register indexes.
module scpl_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic                        i_action,
    input  logic [scpl_pkg::TID_W-1:0]  i_term_id,
    input  logic [scpl_pkg::DOC_W-1:0]  i_doc_id,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [2:0]                  o_status,
    input  logic [scpl_pkg::DOC_W-1:0]  o_posting,
    input  logic                        o_last,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [scpl_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [scpl_pkg::CDAT_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    typedef struct {
        scpl_pkg::t_status status;
        logic [31:0]       posting;
        logic              last;
    } t_posting_result;

    t_posting_result result_q[$];

    logic [8:0]  term_count;
    logic [3:0]  slab_depth;
    logic [3:0]  slab_limit;

    logic        list_ok [scpl_pkg::TERM_SLOTS];
    logic [3:0]  list_head [scpl_pkg::TERM_SLOTS];
    logic [3:0]  list_tail [scpl_pkg::TERM_SLOTS];
    logic        link_ok [scpl_pkg::POOL_SLABS];
    logic [3:0]  link_next [scpl_pkg::POOL_SLABS];
    logic [3:0]  slab_used [scpl_pkg::POOL_SLABS];
    logic [31:0] slab_docs [scpl_pkg::POOL_SLABS*scpl_pkg::SLAB_CAP];
    logic [3:0]  pool_top;

    task automatic push_result(scpl_pkg::t_status st, logic [31:0] doc, logic lst);
        t_posting_result r;
        r.status  = st;
        r.posting = doc;
        r.last    = lst;
        result_q.push_back(r);
    endtask

    task automatic predict_append(logic [15:0] tid, logic [31:0] doc);
        int size, lim, terms, s, idx;
        size  = (slab_depth > scpl_pkg::SLAB_CAP) ? scpl_pkg::SLAB_CAP : slab_depth;
        lim   = (slab_limit > scpl_pkg::POOL_SLABS) ? scpl_pkg::POOL_SLABS : slab_limit;
        terms = (term_count > scpl_pkg::TERM_SLOTS) ? scpl_pkg::TERM_SLOTS : term_count;
        if (tid >= terms) begin
            push_result(scpl_pkg::ST_BAD_TERM, '0, 1'b1);
            return;
        end
        s = list_tail[tid];
        // a zero slab size makes every tail count as full
        if (!list_ok[tid] || slab_used[s] >= size) begin
            idx = pool_top;
            if (idx >= lim) begin
                push_result(scpl_pkg::ST_NO_SLABS, '0, 1'b1);
                return;
            end
            pool_top       = 4'(idx + 1);
            link_ok[idx]   = 1'b0;
            link_next[idx] = '0;
            slab_used[idx] = '0;
            if (!list_ok[tid]) begin
                list_head[tid] = 4'(idx);
                list_ok[tid]   = 1'b1;
            end else begin
                link_next[s] = 4'(idx);
                link_ok[s]   = 1'b1;
            end
            list_tail[tid] = 4'(idx);
            s = idx;
        end
        if (slab_used[s] < scpl_pkg::SLAB_CAP) begin
            slab_docs[s*scpl_pkg::SLAB_CAP + slab_used[s]] = doc;
            slab_used[s] = 4'(slab_used[s] + 4'd1);
        end
        push_result(scpl_pkg::ST_APPENDED, '0, 1'b1);
    endtask

    task automatic predict_read(logic [15:0] tid);
        int terms, s, n;
        terms = (term_count > scpl_pkg::TERM_SLOTS) ? scpl_pkg::TERM_SLOTS : term_count;
        n = 0;
        if (tid < terms && list_ok[tid]) begin
            s = list_head[tid];
            for (int hop = 0; hop < scpl_pkg::POOL_SLABS && s < scpl_pkg::POOL_SLABS;
                 hop++) begin
                for (int i = 0; i < slab_used[s]; i++) begin
                    push_result(scpl_pkg::ST_POSTING, slab_docs[s*scpl_pkg::SLAB_CAP + i], 1'b0);
                    n++;
                end
                if (!link_ok[s]) break;
                s = link_next[s];
            end
        end
        if (n == 0) push_result(scpl_pkg::ST_EMPTY, '0, 1'b1);
        else result_q[result_q.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_checked    = 0;
            o_pending    = 0;
            term_count   = 9'd256;
            slab_depth   = 4'd8;
            slab_limit   = 4'd8;
            pool_top     = '0;
            result_q.delete();
            foreach (list_ok[t]) list_ok[t] = 1'b0;
            foreach (link_ok[s]) begin
                link_ok[s]   = 1'b0;
                link_next[s] = '0;
                slab_used[s] = '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    scpl_pkg::CFG_TERM_COUNT: term_count = i_cfg_data;
                    scpl_pkg::CFG_SLAB_DEPTH: slab_depth = i_cfg_data[3:0];
                    scpl_pkg::CFG_SLAB_LIMIT: slab_limit = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // compare before predicting: a new transaction never affects an older result
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result status=%0d posting=%h", o_status, o_posting);
                    o_fail_count++;
                end else begin
                    t_posting_result r;
                    r = result_q.pop_front();
                    o_checked++;
                    if (o_status !== r.status) begin
                        $error("status: expected %0d, got %0d", r.status, o_status);
                        o_fail_count++;
                    end
                    if (o_posting !== r.posting) begin
                        $error("posting: expected %h, got %h", r.posting, o_posting);
                        o_fail_count++;
                    end
                    if (o_last !== r.last) begin
                        $error("last: expected %0d, got %0d", r.last, o_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (i_action == scpl_pkg::ACT_APPEND) predict_append(i_term_id, i_doc_id);
                else predict_read(i_term_id);
            end
            o_pending = result_q.size();
        end
    end

endmodule

// ===== bench/tb_slab_chained_posting_lists.sv =====
// Testbench top for slab_chained_posting_lists: clock, reset, stimulus and verdict.
// Depends on scpl_pkg, the block under hdl/ and scpl_checker.
module tb_slab_chained_posting_lists;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic                          i_action  = scpl_pkg::ACT_APPEND;
    logic [scpl_pkg::TID_W-1:0]    i_term_id = '0;
    logic [scpl_pkg::DOC_W-1:0]    i_doc_id  = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [2:0]                    o_status;
    logic [scpl_pkg::DOC_W-1:0]    o_posting;
    logic                          o_last;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [scpl_pkg::CIDX_W-1:0]   i_cfg_index = scpl_pkg::CFG_TERM_COUNT;
    logic [scpl_pkg::CDAT_W-1:0]   i_cfg_data  = '0;

    int fail_count, pending, checked;
    int sent_count = 0;

    // idle odds in percent, set per phase
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic rx_hold = 1'b0;

    always #6 i_clk = ~i_clk;

    slab_chained_posting_lists u_dut (.*);

    scpl_checker u_checker (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // receiver side: random stalls, or a long hold-off while rx_hold is set
    always @(posedge i_clk) begin
        i_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // one input transaction; valid stays high from one item to the next when no gap is drawn
    task automatic send_posting_op(logic act, logic [15:0] tid, logic [31:0] doc);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_term_id <= tid;
        i_doc_id  <= doc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // let the block settle after the last result before touching registers
        repeat (6) @(posedge i_clk);
    endtask

    // writes all three registers back to back; valid drops only after the last
    task automatic write_registers(logic [8:0] terms, logic [3:0] size, logic [3:0] limit);
        logic [8:0] vals [3];
        logic [scpl_pkg::CIDX_W-1:0] idxs [3];
        vals = '{terms, {5'd0, size}, {5'd0, limit}};
        idxs = '{scpl_pkg::CFG_TERM_COUNT, scpl_pkg::CFG_SLAB_DEPTH, scpl_pkg::CFG_SLAB_LIMIT};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_posting_ops(int count);
        logic [15:0] tid;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(9);
            // mostly a handful of terms so lists grow and get read back
            if (pick < 6)       tid = 16'($urandom_range(7));
            else if (pick < 8)  tid = 16'($urandom_range(300));
            else if (pick == 8) tid = 16'($urandom_range(65535));
            else                tid = 16'($urandom_range(260, 250));
            send_posting_op(($urandom_range(99) < 40) ? scpl_pkg::ACT_READ : scpl_pkg::ACT_APPEND,
                            tid, $urandom);
        end
    endtask

    // register settings per phase: term_count, slab_size, slab_limit
    logic [8:0] phase_terms [8] = '{9'd511, 9'd0,  9'd4, 9'd256, 9'd16, 9'd300, 9'd1,  9'd256};
    logic [3:0] phase_size  [8] = '{4'd15,  4'd1,  4'd0, 4'd2,   4'd8,  4'd1,   4'd8,  4'd8};
    logic [3:0] phase_limit [8] = '{4'd0,   4'd8,  4'd2, 4'd5,   4'd8,  4'd15,  4'd8,  4'd3};

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset settings: extremes of term and doc, empty and bad terms
        send_posting_op(scpl_pkg::ACT_READ,   16'd0,     32'h0);
        send_posting_op(scpl_pkg::ACT_APPEND, 16'd256,   32'hFFFF_FFFF);
        send_posting_op(scpl_pkg::ACT_APPEND, 16'hFFFF,  32'h1234_5678);
        send_posting_op(scpl_pkg::ACT_READ,   16'hFFFF,  32'hFFFF_FFFF);
        send_posting_op(scpl_pkg::ACT_APPEND, 16'd0,     32'h0);
        send_posting_op(scpl_pkg::ACT_APPEND, 16'd0,     32'hFFFF_FFFF);
        send_posting_op(scpl_pkg::ACT_APPEND, 16'd255,   32'hA5A5_5A5A);
        send_posting_op(scpl_pkg::ACT_READ,   16'd0,     32'h0);
        send_posting_op(scpl_pkg::ACT_READ,   16'd255,   32'h0);
        send_posting_op(scpl_pkg::ACT_READ,   16'd1,     32'h0);
        for (int k = 0; k < 7; k++)
            send_posting_op(scpl_pkg::ACT_APPEND, 16'd0, 32'h5A5A_0000 | k);
        send_posting_op(scpl_pkg::ACT_READ, 16'd0, 32'h0);
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            write_registers(phase_terms[ph], phase_size[ph], phase_limit[ph]);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
                default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
            endcase
            if (ph == 4) begin
                // long receiver hold-off: the output backs up and input stalls
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (300) @(posedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            random_posting_ops(20);
            if (ph == 5) begin
                // sender pauses mid-phase until everything is out
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            random_posting_ops(20);
            drain_results();
        end

        $display("covered %0d input transactions and %0d results over 9 register settings",
                 sent_count, checked);
        $display("including bad terms, empty lists, exhausted pool and a long output stall");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("status: fail");
        $finish;
    end

endmodule
